@@ design/cnv_pkg.sv @@
package cnv_pkg;

	localparam int PIX_W   = 24;
	localparam int CHAN_W  = 8;
	localparam int ACC_W   = 20;
	localparam int GAIN_W  = 16;
	localparam int BIAS_W  = 9;
	localparam int DIM_W   = 11;
	localparam int FRAC_W  = 12;
	localparam int ROW_MAX = 2047;
	localparam int MAX_HEIGHT = 1024;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	// register indexes (word addresses)
	localparam logic [2:0] REG_KX_MINUS = 3'd0;
	localparam logic [2:0] REG_KX_ZERO  = 3'd1;
	localparam logic [2:0] REG_KX_PLUS  = 3'd2;
	localparam logic [2:0] REG_GAIN     = 3'd3;
	localparam logic [2:0] REG_BIAS     = 3'd4;
	localparam logic [2:0] REG_WIDTH    = 3'd5;
	localparam logic [2:0] REG_HEIGHT   = 3'd6;

	localparam logic KIND_FLUSH = 1'b1;

	typedef struct packed {
		logic [23:0]              kx_minus;
		logic [23:0]              kx_zero;
		logic [23:0]              kx_plus;
		logic [GAIN_W-1:0]        gain;
		logic signed [BIAS_W-1:0] bias;
		logic [DIM_W-1:0]         width;
		logic [DIM_W-1:0]         height;
	} cnv_cfg_t;

	typedef struct packed {
		logic             valid;
		logic [PIX_W-1:0] pix;
	} cnv_item_t;

endpackage

@@ design/cnv_ram.sv @@
module cnv_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

@@ design/cnv_front.sv @@
// Input side: folds flush items to zero pixels and buffers two items.
module cnv_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   kind,
	input  logic [7:0]             red_in,
	input  logic [7:0]             green_in,
	input  logic [7:0]             blue_in,
	output cnv_pkg::cnv_item_t     item,
	input  logic                   pop
);
	import cnv_pkg::*;

	logic [PIX_W-1:0] buf_q [2];
	logic [1:0]       cnt_q;
	logic             rd_q;
	logic             wr_q;
	logic             push;
	logic             do_pop;
	logic [PIX_W-1:0] pix;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign do_pop   = pop && (cnt_q != 2'd0);
	assign pix      = (kind == KIND_FLUSH) ? '0 : {red_in, green_in, blue_in};

	assign item.valid = (cnt_q != 2'd0);
	assign item.pix   = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= pix;
		end
	end
endmodule

@@ design/cnv_back.sv @@
// Execution side: line store, window, tap-serial MAC, scale and saturate.
module cnv_back #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cnv_pkg::cnv_cfg_t  cfg,
	input  cnv_pkg::cnv_item_t item,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         red_out,
	output logic [7:0]         green_out,
	output logic [7:0]         blue_out,
	output logic               frame_done
);
	import cnv_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int EW = (WW > DIM_W) ? WW : DIM_W;
	localparam int HW = $clog2(MAX_HEIGHT);
	localparam int PW = ACC_W + GAIN_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_MAC, ST_SCALE, ST_FIN
	} state_t;

	state_t           state_q;
	logic [PIX_W-1:0] pix_q;
	logic [AW-1:0]    col_q;
	logic [DIM_W-1:0] row_q;
	logic [AW-1:0]    ox_q;
	logic [HW-1:0]    oy_q;
	logic [PIX_W-1:0] win_q [3][3];
	logic [1:0]       ti_q, tj_q;
	logic signed [ACC_W-1:0] acc_q [3];
	logic signed [PW-1:0]    prod_q [3];
	logic [7:0]       res_q [3];
	logic             done_q;
	logic             ovalid_q;

	logic [EW-1:0]    w_eff, h_eff, fw_ext, fh_ext;
	logic [2*PIX_W-1:0] rdata;
	logic [PIX_W-1:0] upper, lower;
	logic             primed;
	logic             col_wrap;
	logic [1:0]       colsel [3];
	logic [1:0]       rowsel [3];
	logic [PIX_W-1:0] tap_px;
	logic [23:0]      kreg;
	logic signed [7:0] wt;
	logic             out_last;
	logic             out_free;

	assign fw_ext = EW'(cfg.width);
	assign fh_ext = EW'(cfg.height);
	always_comb begin
		w_eff = fw_ext;
		if (fw_ext == '0) w_eff = EW'(1);
		else if (fw_ext > EW'(MAX_WIDTH)) w_eff = EW'(MAX_WIDTH);
		h_eff = fh_ext;
		if (fh_ext == '0) h_eff = EW'(1);
		else if (fh_ext > EW'(MAX_HEIGHT)) h_eff = EW'(MAX_HEIGHT);
	end

	// one RAM holds both line stores: {upper, lower}
	cnv_ram #(.WIDTH(2 * PIX_W), .DEPTH(MAX_WIDTH)) u_lines (
		.clk   (clk),
		.we    (state_q == ST_READ),
		.waddr (col_q),
		.wdata ({lower, pix_q}),
		.raddr (col_q),
		.rdata (rdata)
	);
	assign upper = rdata[2*PIX_W-1:PIX_W];
	assign lower = rdata[PIX_W-1:0];

	assign primed   = (row_q >= DIM_W'(2)) || (row_q == DIM_W'(1) && col_q != '0);
	assign col_wrap = (EW'(col_q) + EW'(1)) >= w_eff;

	always_comb begin
		colsel[0] = (ox_q == '0) ? 2'd1 : 2'd0;
		colsel[1] = 2'd1;
		colsel[2] = (EW'(ox_q) >= w_eff - EW'(1)) ? 2'd1 : 2'd2;
		rowsel[0] = (oy_q == '0) ? 2'd1 : 2'd0;
		rowsel[1] = 2'd1;
		rowsel[2] = (EW'(oy_q) >= h_eff - EW'(1)) ? 2'd1 : 2'd2;
	end

	assign tap_px = win_q[colsel[ti_q]][rowsel[tj_q]];
	always_comb begin
		case (ti_q)
			2'd0:    kreg = cfg.kx_minus;
			2'd1:    kreg = cfg.kx_zero;
			default: kreg = cfg.kx_plus;
		endcase
		case (tj_q)
			2'd0:    wt = $signed(kreg[7:0]);
			2'd1:    wt = $signed(kreg[15:8]);
			default: wt = $signed(kreg[23:16]);
		endcase
	end

	assign out_last = (EW'(ox_q) >= w_eff - EW'(1)) && (EW'(oy_q) >= h_eff - EW'(1));
	assign out_free = !ovalid_q || !out_stall;
	assign pop      = (state_q == ST_IDLE) && item.valid;

	function automatic logic [7:0] sat_chan(input logic signed [PW-1:0] p,
		input logic signed [BIAS_W-1:0] b);
		logic signed [PW-FRAC_W:0] v;
		begin
			v = (PW-FRAC_W+1)'(p >>> FRAC_W) + (PW-FRAC_W+1)'(b);
			if (v < 0) sat_chan = 8'd0;
			else if (v > 255) sat_chan = 8'd255;
			else sat_chan = v[7:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			col_q    <= '0;
			row_q    <= '0;
			ox_q     <= '0;
			oy_q     <= '0;
			ti_q     <= '0;
			tj_q     <= '0;
			ovalid_q <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				for (int r = 0; r < 3; r++) begin
					win_q[c][r] <= '0;
				end
			end
		end else begin
			// output register: load a finished pixel, or empty once taken
			if (state_q == ST_FIN && out_free) begin
				ovalid_q <= 1'b1;
			end else if (ovalid_q && !out_stall) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						pix_q   <= item.pix;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					win_q[0] <= win_q[1];
					win_q[1] <= win_q[2];
					win_q[2][0] <= upper;
					win_q[2][1] <= lower;
					win_q[2][2] <= pix_q;
					if (col_wrap) begin
						col_q <= '0;
						if (row_q != DIM_W'(ROW_MAX)) row_q <= row_q + DIM_W'(1);
					end else begin
						col_q <= col_q + AW'(1);
					end
					for (int k = 0; k < 3; k++) acc_q[k] <= '0;
					ti_q    <= '0;
					tj_q    <= '0;
					state_q <= primed ? ST_MAC : ST_IDLE;
				end
				ST_MAC: begin
					for (int k = 0; k < 3; k++) begin
						acc_q[k] <= acc_q[k] + ACC_W'($signed({1'b0,
							tap_px[PIX_W-1-8*k -: 8]})) * ACC_W'(wt);
					end
					if (tj_q == 2'd2) begin
						tj_q <= '0;
						ti_q <= ti_q + 2'd1;
						if (ti_q == 2'd2) state_q <= ST_SCALE;
					end else begin
						tj_q <= tj_q + 2'd1;
					end
				end
				ST_SCALE: begin
					for (int k = 0; k < 3; k++) begin
						prod_q[k] <= PW'(acc_q[k]) * PW'($signed({1'b0, cfg.gain}));
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						for (int k = 0; k < 3; k++) res_q[k] <= sat_chan(prod_q[k], cfg.bias);
						done_q   <= out_last;
						if (out_last) begin
							ox_q  <= '0;
							oy_q  <= '0;
							col_q <= '0;
							row_q <= '0;
						end else if (EW'(ox_q) + EW'(1) >= w_eff) begin
							ox_q <= '0;
							oy_q <= oy_q + HW'(1);
						end else begin
							ox_q <= ox_q + AW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = ovalid_q;
	assign red_out    = res_q[0];
	assign green_out  = res_q[1];
	assign blue_out   = res_q[2];
	assign frame_done = done_q;
endmodule

@@ design/rgb_convolution_3x3.sv @@
// Channel   | Handshake               | Payload
// ----------+-------------------------+----------------------------------------
// input     | in_valid / in_stall     | kind, red_in, green_in, blue_in
// output    | out_valid / out_stall   | red_out, green_out, blue_out, frame_done
// config    | APB psel/penable/pready | paddr, pwdata, prdata
//
// An item that only primes the window goes through pop and line-store read; one
// that yields a pixel goes on through nine taps in turn on one 8x8 multiplier
// per channel, the gain multiply, then the saturating output stage.
// arst_n clears counters, window and handshake state; line stores are not
// cleared, their unwritten entries are never selected by the edge clamp.
// A two-entry input queue absorbs two transfers while the back end works;
// out_stall holds the finished pixel in the output register.
module rgb_convolution_3x3 #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            kind,
	input  logic [7:0]                      red_in,
	input  logic [7:0]                      green_in,
	input  logic [7:0]                      blue_in,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      red_out,
	output logic [7:0]                      green_out,
	output logic [7:0]                      blue_out,
	output logic                            frame_done,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cnv_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [cnv_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [cnv_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import cnv_pkg::*;

	cnv_cfg_t  cfg_q;
	cnv_item_t item;
	logic      pop;
	logic      wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	// register file, written on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kx_minus <= 24'hFFFFFF;
			cfg_q.kx_zero  <= 24'hFF08FF;
			cfg_q.kx_plus  <= 24'hFFFFFF;
			cfg_q.gain     <= GAIN_W'(5461);
			cfg_q.bias     <= '0;
			cfg_q.width    <= DIM_W'(640);
			cfg_q.height   <= DIM_W'(480);
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_KX_MINUS: cfg_q.kx_minus <= pwdata[23:0];
				REG_KX_ZERO:  cfg_q.kx_zero  <= pwdata[23:0];
				REG_KX_PLUS:  cfg_q.kx_plus  <= pwdata[23:0];
				REG_GAIN:     cfg_q.gain     <= pwdata[GAIN_W-1:0];
				REG_BIAS:     cfg_q.bias     <= $signed(pwdata[BIAS_W-1:0]);
				REG_WIDTH:    cfg_q.width    <= pwdata[DIM_W-1:0];
				REG_HEIGHT:   cfg_q.height   <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_KX_MINUS: prdata = APB_DATA_W'(cfg_q.kx_minus);
			REG_KX_ZERO:  prdata = APB_DATA_W'(cfg_q.kx_zero);
			REG_KX_PLUS:  prdata = APB_DATA_W'(cfg_q.kx_plus);
			REG_GAIN:     prdata = APB_DATA_W'(cfg_q.gain);
			REG_BIAS:     prdata = APB_DATA_W'($unsigned(cfg_q.bias));
			REG_WIDTH:    prdata = APB_DATA_W'(cfg_q.width);
			REG_HEIGHT:   prdata = APB_DATA_W'(cfg_q.height);
			default:      prdata = '0;
		endcase
	end

	cnv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.red_in   (red_in),
		.green_in (green_in),
		.blue_in  (blue_in),
		.item     (item),
		.pop      (pop)
	);

	cnv_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item       (item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.frame_done (frame_done)
	);
endmodule

@@ verif/rgb_convolution_3x3_tb.sv @@
`timescale 1ns / 1ps

module rgb_convolution_3x3_tb;
	import cnv_pkg::*;

	localparam int LINE_DEPTH = 1024;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic       kind;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_item_t;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       done;
	} filtered_pixel_t;

	// DUT signals; the driven inputs are known from time zero
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  kind = 1'b0;
	logic [7:0]            red_in = '0;
	logic [7:0]            green_in = '0;
	logic [7:0]            blue_in = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [7:0]            red_out;
	logic [7:0]            green_out;
	logic [7:0]            blue_out;
	logic                  frame_done;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	rgb_convolution_3x3 uut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// stimulus waiting for the driver, filtered pixels waiting for the monitor
	pixel_item_t     pixel_feed[$];
	filtered_pixel_t filtered_q[$];
	int              send_idle_pct = 32;
	int              recv_idle_pct = 55;
	bit              failed = 1'b0;

	// ---------------------------------------------------------------------
	// Filter mirror: register copies plus line stores, window and counters
	// ---------------------------------------------------------------------
	logic [23:0]        kx_minus_m = 24'hFFFFFF;
	logic [23:0]        kx_zero_m  = 24'hFF08FF;
	logic [23:0]        kx_plus_m  = 24'hFFFFFF;
	logic [15:0]        gain_m     = 16'd5461;
	logic signed [8:0]  bias_m     = 9'sd0;
	logic [10:0]        width_m    = 11'd640;
	logic [10:0]        height_m   = 11'd480;

	logic [23:0] upper_line[LINE_DEPTH];
	logic [23:0] lower_line[LINE_DEPTH];
	logic [23:0] win[3][3]; // [column left..right][row top..bottom]
	int unsigned col_cnt = 0, row_cnt = 0, emit_cnt = 0;

	initial begin
		foreach (win[i, j]) win[i][j] = '0;
		foreach (upper_line[i]) begin
			upper_line[i] = '0;
			lower_line[i] = '0;
		end
	end

	function automatic int unsigned clamp_dim(logic [10:0] v, int unsigned top);
		if (v == 0) return 1;
		if (v > top) return top;
		return v;
	endfunction

	// floor(sum * gain / 4096) + bias, saturated to a byte
	function automatic logic [7:0] scale_channel(longint sum);
		longint v;
		v = ((sum * longint'(gain_m)) >>> 12) + longint'(bias_m);
		if (v < 0) return 8'd0;
		if (v > 255) return 8'd255;
		return v[7:0];
	endfunction

	// advance the stream by one transfer; returns 1 when a filtered pixel results
	function automatic bit filter_step(pixel_item_t it, output filtered_pixel_t res);
		int unsigned w, h, ox, oy;
		int unsigned cs[3], rs[3];
		logic [23:0] pix, px, kreg[3];
		longint sum[3];
		bit primed;
		w = clamp_dim(width_m, LINE_DEPTH);
		h = clamp_dim(height_m, MAX_HEIGHT);
		primed = row_cnt >= 2 || (row_cnt == 1 && col_cnt >= 1);
		pix = (it.kind == KIND_FLUSH) ? 24'd0 : {it.red, it.green, it.blue};

		for (int i = 0; i < 2; i++)
			for (int j = 0; j < 3; j++) win[i][j] = win[i+1][j];
		win[2][0] = upper_line[col_cnt];
		win[2][1] = lower_line[col_cnt];
		win[2][2] = pix;
		upper_line[col_cnt] = lower_line[col_cnt];
		lower_line[col_cnt] = pix;

		if (col_cnt + 1 >= w) begin
			col_cnt = 0;
			if (row_cnt < ROW_MAX) row_cnt++;
		end else begin
			col_cnt++;
		end
		if (!primed) return 1'b0;

		ox = emit_cnt % w;
		oy = emit_cnt / w;
		// edge clamp: a neighbor outside the frame is replaced by the center
		cs[0] = (ox == 0) ? 1 : 0;
		cs[1] = 1;
		cs[2] = (ox >= w - 1) ? 1 : 2;
		rs[0] = (oy == 0) ? 1 : 0;
		rs[1] = 1;
		rs[2] = (oy >= h - 1) ? 1 : 2;
		kreg[0] = kx_minus_m;
		kreg[1] = kx_zero_m;
		kreg[2] = kx_plus_m;
		sum[0] = 0; sum[1] = 0; sum[2] = 0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				px = win[cs[i]][rs[j]];
				for (int k = 0; k < 3; k++)
					sum[k] += longint'(px[16-8*k +: 8]) *
						longint'($signed(kreg[i][8*j +: 8]));
			end

		res.red = scale_channel(sum[0]);
		res.green = scale_channel(sum[1]);
		res.blue = scale_channel(sum[2]);
		res.done = (emit_cnt + 1 >= w * h);
		if (res.done) begin
			emit_cnt = 0;
			col_cnt = 0;
			row_cnt = 0;
		end else begin
			emit_cnt = (emit_cnt + 1) & 20'hFFFFF;
		end
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------------
	// Driver: pops the feed, holds a stalled transfer, predicts on acceptance
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : driver
		filtered_pixel_t res;
		pixel_item_t it;
		bit busy;
		busy = in_valid;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				it.kind = kind;
				it.red = red_in;
				it.green = green_in;
				it.blue = blue_in;
				if (filter_step(it, res)) filtered_q.push_back(res);
				busy = 1'b0;
			end
			// valid only drops after an accepted transfer, never while stalled
			if (!busy) begin
				if (pixel_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					it = pixel_feed.pop_front();
					kind <= it.kind;
					red_in <= it.red;
					green_in <= it.green;
					blue_in <= it.blue;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: random back-pressure, field-by-field compare
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		filtered_pixel_t exp_pix;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (filtered_q.size() == 0) begin
					$error("filtered pixel with none expected");
					failed = 1'b1;
				end else begin
					exp_pix = filtered_q.pop_front();
					if (red_out !== exp_pix.red) begin
						$error("red_out expected %0d got %0d", exp_pix.red, red_out);
						failed = 1'b1;
					end
					if (green_out !== exp_pix.green) begin
						$error("green_out expected %0d got %0d", exp_pix.green, green_out);
						failed = 1'b1;
					end
					if (blue_out !== exp_pix.blue) begin
						$error("blue_out expected %0d got %0d", exp_pix.blue, blue_out);
						failed = 1'b1;
					end
					if (frame_done !== exp_pix.done) begin
						$error("frame_done expected %0d got %0d", exp_pix.done, frame_done);
						failed = 1'b1;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// ---------------------------------------------------------------------
	// APB write: setup cycle, access cycle; the mirror follows the register
	// ---------------------------------------------------------------------
	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_KX_MINUS: kx_minus_m = val[23:0];
			REG_KX_ZERO:  kx_zero_m = val[23:0];
			REG_KX_PLUS:  kx_plus_m = val[23:0];
			REG_GAIN:     gain_m = val[15:0];
			REG_BIAS:     bias_m = val[8:0];
			REG_WIDTH:    width_m = val[10:0];
			REG_HEIGHT:   height_m = val[10:0];
			default: ;
		endcase
	endtask

	task automatic load_setup(logic [23:0] km, logic [23:0] kz, logic [23:0] kp,
			logic [15:0] g, int b, logic [10:0] w, logic [10:0] h);
		logic [8:0] b9;
		b9 = 9'(b);
		reg_write(REG_KX_MINUS, 32'(km));
		reg_write(REG_KX_ZERO, 32'(kz));
		reg_write(REG_KX_PLUS, 32'(kp));
		reg_write(REG_GAIN, 32'(g));
		reg_write(REG_BIAS, 32'(b9));
		reg_write(REG_WIDTH, 32'(w));
		reg_write(REG_HEIGHT, 32'(h));
	endtask

	// a whole frame: W*H frame transfers (a flush at flush_pct), then W+1 trailing transfers (flush or pixel)
	task automatic queue_frame(int flush_pct, int trail_pixel_pct);
		pixel_item_t it;
		int unsigned w, h;
		w = clamp_dim(width_m, LINE_DEPTH);
		h = clamp_dim(height_m, MAX_HEIGHT);
		for (int n = 0; n < w * h + w + 1; n++) begin
			it.red = 8'($urandom);
			it.green = 8'($urandom);
			it.blue = 8'($urandom);
			if (n < w * h) it.kind = ($urandom_range(99) < flush_pct);
			else it.kind = ($urandom_range(99) >= trail_pixel_pct);
			pixel_feed.push_back(it);
		end
	endtask

	task automatic push_pixel(logic k, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		pixel_item_t it;
		it.kind = k;
		it.red = r;
		it.green = g;
		it.blue = b;
		pixel_feed.push_back(it);
	endtask

	// wait until every transfer is in and every filtered pixel is out
	task automatic drain;
		while (pixel_feed.size() != 0 || in_valid || filtered_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_kernel();
		return $urandom_range(3) == 0 ? 24'($urandom) :
			{8'($signed($urandom_range(8)) - 4), 8'($signed($urandom_range(16)) - 4),
			 8'($signed($urandom_range(8)) - 4)};
	endfunction

	initial begin
		int frames;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default sharpen kernel, 3x3 frame, black/white extremes
		load_setup(24'hFFFFFF, 24'hFF08FF, 24'hFFFFFF, 16'd5461, 0, 11'd3, 11'd3);
		push_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
		push_pixel(1'b0, 8'h00, 8'h00, 8'h00);
		push_pixel(1'b0, 8'hFF, 8'h00, 8'hAA);
		push_pixel(1'b0, 8'h00, 8'hFF, 8'h55);
		push_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
		push_pixel(1'b0, 8'h00, 8'h00, 8'h00);
		push_pixel(1'b0, 8'h80, 8'h7F, 8'h01);
		push_pixel(1'b0, 8'hFE, 8'h01, 8'hFF);
		push_pixel(1'b0, 8'h00, 8'hFF, 8'h00);
		repeat (4) push_pixel(KIND_FLUSH, 8'hFF, 8'hFF, 8'hFF);
		drain();

		// most negative weights, full gain, max bias; a flush inside the frame
		// and pixels instead of flushes after the frame's last pixel
		load_setup(24'h808080, 24'h808080, 24'h808080, 16'hFFFF, 255, 11'd4, 11'd2);
		for (int n = 0; n < 8; n++)
			push_pixel(n == 5 ? KIND_FLUSH : 1'b0, n[0] ? 8'hFF : 8'h00, 8'h80, 8'hFF);
		repeat (5) push_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
		drain();

		// most positive weights, bias -255: zero gain on a single pixel frame, then gain 1, width 0, height 2
		load_setup(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 16'd0, -255, 11'd1, 11'd1);
		queue_frame(0, 50);
		drain();
		load_setup(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 16'd1, -255, 11'd0, 11'd2);
		queue_frame(10, 50);
		drain();

		// zero width and height both fall back to a single pixel
		load_setup(rand_kernel(), rand_kernel(), rand_kernel(), 16'd4096, -17, 11'd0,
			11'd0);
		queue_frame(5, 50);
		drain();

		// random frames, small sizes; sender and receiver idling swapped, then none
		frames = 0;
		while (frames < 40) begin
			if (frames >= 26) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (frames >= 13) begin
				send_idle_pct = 55;
				recv_idle_pct = 32;
			end
			load_setup(rand_kernel(), rand_kernel(), rand_kernel(),
				$urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(300, 9000)),
				$urandom_range(3) == 0 ? int'($urandom_range(510)) - 255 :
					int'($urandom_range(40)) - 20,
				11'($urandom_range(1, 7)), 11'($urandom_range(1, 5)));
			repeat ($urandom_range(1, 2)) begin
				queue_frame($urandom_range(3) == 0 ? 15 : 0, $urandom_range(100));
				frames++;
			end
			drain();
		end

		if (!failed) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// generous ceiling over the slowest correct run
	initial begin
		#40ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
